### rtl/es2cf_pkg.sv
// Constants and tables shared by the epoch-to-calendar pipeline.
// No dependencies; used by es2cf_civil and epoch_seconds_to_calendar_fields.
package es2cf_pkg;

  // Day split: secs / 86400 == (secs >> 7) / 675, reciprocal with 35 fraction bits
  localparam logic [25:0] RecipDay   = 26'd50903317;
  localparam int unsigned DayShift   = 35;
  localparam logic [16:0] SecsPerDay = 17'd86400;

  // Shift day 0 to 0000-03-01, then subtract the era base (era is 4 or 5 here)
  localparam logic [19:0] EpochShift = 20'd719468;
  localparam logic [19:0] Era4Base   = 20'd584388;
  localparam logic [19:0] Era5Base   = 20'd730485;

  // Century boundaries inside an era
  localparam logic [17:0] Cent1 = 18'd36524;
  localparam logic [17:0] Cent2 = 18'd73048;
  localparam logic [17:0] Cent3 = 18'd109572;
  localparam logic [17:0] Cent4 = 18'd146096;

  // (doe >> 2) / 365 with 25 fraction bits gives doe / 1460
  localparam logic [16:0] Recip1460 = 17'd91930;
  // n / 365 with 27 fraction bits
  localparam logic [18:0] Recip365  = 19'd367720;
  // v / 153 with 19 fraction bits
  localparam logic [11:0] Recip153  = 12'd3427;

  // (sod >> 4) / 225 with 21 fraction bits gives sod / 3600
  localparam logic [13:0] Recip3600   = 14'd9321;
  localparam logic [16:0] SecsPerHour = 17'd3600;
  // (rh >> 2) / 15 with 14 fraction bits gives rh / 60
  localparam logic [10:0] Recip60     = 11'd1093;
  localparam logic [11:0] SecsPerMin  = 12'd60;

  // First day of year (March based) for each shifted month: (153 * mp + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] res;
    case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

### rtl/es2cf_civil.sv
// Civil-from-days pipeline: day count since 1970-01-01 to month and day of month.
// Seven register levels, one item per cycle. Uses es2cf_pkg.
module es2cf_civil (
  input  logic        clk_i,
  input  logic [15:0] days_i,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o
);

  logic [19:0] z;
  logic [17:0] doe_d;
  logic [17:0] s2_doe_q;

  logic [32:0] s3_pa_q;
  logic [17:0] s3_doe_q;

  logic [7:0]  qa;
  logic [2:0]  qb;
  logic        qc;
  logic [17:0] n_d;
  logic [17:0] s4_n_q;
  logic [17:0] s4_doe_q;

  logic [35:0] s5_py_q;
  logic [17:0] s5_doe_q;

  logic [8:0]  yoe;
  logic [1:0]  c100;
  logic [17:0] yday0;
  logic [8:0]  doy_d;
  logic [8:0]  s6_doy_q;

  logic [10:0] v5;
  logic [22:0] s7_pm_q;
  logic [8:0]  s7_doy_q;

  logic [3:0]  mp;
  logic [3:0]  month_q;
  logic [4:0]  day_q;

  // Day of era: era is 4 or 5 over the whole 32-bit seconds range
  assign z     = 20'(days_i) + es2cf_pkg::EpochShift;
  assign doe_d = (z >= es2cf_pkg::Era5Base) ? 18'(z - es2cf_pkg::Era5Base)
                                            : 18'(z - es2cf_pkg::Era4Base);

  // Leap corrections: doe / 1460, doe / 36524, doe / 146096
  assign qa = s3_pa_q[32:25];

  always_comb begin
    if (s3_doe_q >= es2cf_pkg::Cent4) begin
      qb = 3'd4;
    end else if (s3_doe_q >= es2cf_pkg::Cent3) begin
      qb = 3'd3;
    end else if (s3_doe_q >= es2cf_pkg::Cent2) begin
      qb = 3'd2;
    end else if (s3_doe_q >= es2cf_pkg::Cent1) begin
      qb = 3'd1;
    end else begin
      qb = 3'd0;
    end
  end

  assign qc  = (s3_doe_q == es2cf_pkg::Cent4);
  assign n_d = 18'(s3_doe_q - 18'(qa) + 18'(qb) - 18'(qc));

  // Year of era and day of year
  assign yoe = s5_py_q[35:27];

  always_comb begin
    if (yoe >= 9'd300) begin
      c100 = 2'd3;
    end else if (yoe >= 9'd200) begin
      c100 = 2'd2;
    end else if (yoe >= 9'd100) begin
      c100 = 2'd1;
    end else begin
      c100 = 2'd0;
    end
  end

  assign yday0 = 18'(18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(c100));
  assign doy_d = 9'(s5_doe_q - yday0);

  assign v5 = 11'(11'(s6_doy_q) * 11'd5 + 11'd2);
  assign mp = s7_pm_q[22:19];

  always_ff @(posedge clk_i) begin
    s2_doe_q <= doe_d;

    s3_pa_q  <= 33'(s2_doe_q[17:2]) * 33'(es2cf_pkg::Recip1460);
    s3_doe_q <= s2_doe_q;

    s4_n_q   <= n_d;
    s4_doe_q <= s3_doe_q;

    s5_py_q  <= 36'(s4_n_q) * 36'(es2cf_pkg::Recip365);
    s5_doe_q <= s4_doe_q;

    s6_doy_q <= doy_d;

    s7_pm_q  <= 23'(v5) * 23'(es2cf_pkg::Recip153);
    s7_doy_q <= s6_doy_q;

    // March-based month back to January-based
    month_q  <= (mp < 4'd10) ? 4'(mp + 4'd3) : 4'(mp - 4'd9);
    day_q    <= 5'(s7_doy_q - es2cf_pkg::month_start(mp) + 9'd1);
  end

  assign month_o = month_q;
  assign day_o   = day_q;

endmodule

### rtl/epoch_seconds_to_calendar_fields.sv
// Top level: seconds since 1970-01-01 to month, day, hour, minute, second.
// Depends on es2cf_pkg and es2cf_civil.
//
//   channel   | ports                                          | transfer when
//   ----------+------------------------------------------------+-------------------
//   command   | start_i, busy_o, epoch_seconds_i,              | start_i && !busy_o
//             | milliseconds_in_i                              |
//   result    | done_o, month_of_year_o, day_of_month_o,       | done_o
//             | hour_of_day_o, minute_of_hour_o,               |
//             | second_of_minute_o, milliseconds_out_o         |
//
// Eight register stages; done_o is the valid bit of the last stage.
// One command per cycle; busy_o stays low, since the pipeline always advances.
// Stage depth is set by one reciprocal multiply per stage (day split, leap
// corrections, year of era, month) with the time-of-day path in parallel.
// Reset clears the valid bits only; results never wait on the receiver.
module epoch_seconds_to_calendar_fields (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] epoch_seconds_i,
  input  logic [9:0]  milliseconds_in_i,
  output logic        done_o,
  output logic [3:0]  month_of_year_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_of_day_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [5:0]  second_of_minute_o,
  output logic [9:0]  milliseconds_out_o
);

  localparam int unsigned NumStages = 8;

  logic                 accept;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] valid_q;
  logic [9:0]           ms_q [NumStages];

  logic [50:0] s1_prod_q;
  logic [31:0] s1_secs_q;
  logic [15:0] days;

  logic [31:0] s2_dsec_q;
  logic [31:0] s2_secs_q;

  logic [16:0] s3_sod_q;

  logic [26:0] s4_ph_q;
  logic [16:0] s4_sod_q;

  logic [4:0]  hour;
  logic [4:0]  s5_hour_q;
  logic [11:0] s5_rh_q;

  logic [20:0] pm60;
  logic [4:0]  s6_hour_q;
  logic [5:0]  s6_min_q;
  logic [11:0] s6_rh_q;

  logic [4:0]  s7_hour_q;
  logic [5:0]  s7_min_q;
  logic [5:0]  s7_sec_q;

  logic [4:0]  hour_q;
  logic [5:0]  min_q;
  logic [5:0]  sec_q;

  assign busy_o  = 1'b0;
  assign accept  = start_i && !busy_o;
  assign valid_d = {valid_q[NumStages-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Milliseconds ride along unchanged
  always_ff @(posedge clk_i) begin
    ms_q[0] <= milliseconds_in_i;
    for (int i = 1; i < NumStages; i++) begin
      ms_q[i] <= ms_q[i-1];
    end
  end

  // Whole days from the reciprocal product; seconds of day follow
  assign days = s1_prod_q[50:35];
  assign hour = s4_ph_q[25:21];
  assign pm60 = 21'(s5_rh_q[11:2]) * 21'(es2cf_pkg::Recip60);

  always_ff @(posedge clk_i) begin
    s1_prod_q <= 51'(epoch_seconds_i[31:7]) * 51'(es2cf_pkg::RecipDay);
    s1_secs_q <= epoch_seconds_i;

    s2_dsec_q <= 32'(33'(days) * 33'(es2cf_pkg::SecsPerDay));
    s2_secs_q <= s1_secs_q;

    s3_sod_q  <= 17'(s2_secs_q - s2_dsec_q);

    s4_ph_q   <= 27'(s3_sod_q[16:4]) * 27'(es2cf_pkg::Recip3600);
    s4_sod_q  <= s3_sod_q;

    s5_hour_q <= hour;
    s5_rh_q   <= 12'(s4_sod_q - 17'(17'(hour) * es2cf_pkg::SecsPerHour));

    s6_hour_q <= s5_hour_q;
    s6_min_q  <= pm60[19:14];
    s6_rh_q   <= s5_rh_q;

    s7_hour_q <= s6_hour_q;
    s7_min_q  <= s6_min_q;
    s7_sec_q  <= 6'(s6_rh_q - 12'(12'(s6_min_q) * es2cf_pkg::SecsPerMin));

    hour_q    <= s7_hour_q;
    min_q     <= s7_min_q;
    sec_q     <= s7_sec_q;
  end

  es2cf_civil u_civil (
    .clk_i   (clk_i),
    .days_i  (days),
    .month_o (month_of_year_o),
    .day_o   (day_of_month_o)
  );

  assign done_o             = valid_q[NumStages-1];
  assign hour_of_day_o      = hour_q;
  assign minute_of_hour_o   = min_q;
  assign second_of_minute_o = sec_q;
  assign milliseconds_out_o = ms_q[NumStages-1];

endmodule
